// ----- sv/tks_pkg.sv -----
package tks_pkg;

	localparam int SCORE_W  = 19;
	localparam int MIN_W    = 17;
	localparam int MAXE_W   = 5;
	localparam int CFG_W    = 17;
	localparam int STATUS_W = 4;

	localparam logic [MIN_W-1:0]  MIN_SCORE_RST   = 17'd25600;
	localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 5'd4;

	// Configuration register indexes.
	localparam logic CFG_MIN_SCORE   = 1'b0;
	localparam logic CFG_MAX_ENTRIES = 1'b1;

	// Input operation codes.
	localparam logic [1:0] OP_OFFER = 2'd0;
	localparam logic [1:0] OP_DUMP  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Command kinds passed from the front end to the table engine.
	typedef enum logic [1:0] {
		K_OFFER = 2'd0,
		K_LOW   = 2'd1,
		K_DUMP  = 2'd2,
		K_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_LOW        = 4'd0,
		ST_SUPPRESSED = 4'd1,
		ST_APPENDED   = 4'd2,
		ST_REPL_WORST = 4'd3,
		ST_FULL       = 4'd4,
		ST_REPL_ONE   = 4'd5,
		ST_MERGED     = 4'd6,
		ST_ENTRY      = 4'd7,
		ST_CLEARED    = 4'd8
	} status_t;

endpackage

// ----- sv/tks_fifo.sv -----
module tks_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

// ----- sv/tks_front.sv -----
module tks_front #(
	parameter int COORD_BITS = 10
) (
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           op,
	input  logic signed [tks_pkg::SCORE_W-1:0]   cand_score,
	input  logic [COORD_BITS-1:0]                rect_x,
	input  logic [COORD_BITS-1:0]                rect_y,
	input  logic [COORD_BITS:0]                  rect_w,
	input  logic [COORD_BITS:0]                  rect_h,
	input  logic [tks_pkg::MIN_W-1:0]            min_score,
	input  logic                                 full,
	output logic                                 push,
	output logic [2+tks_pkg::SCORE_W+4*COORD_BITS+2-1:0] push_data
);

	tks_pkg::kind_t kind;
	logic           keep;
	logic           low;

	// The threshold is unsigned, so compare with two zero bits prepended.
	assign low = (cand_score < $signed({2'b00, min_score}));

	always_comb begin
		kind = tks_pkg::K_OFFER;
		keep = 1'b1;
		unique case (op)
			tks_pkg::OP_OFFER: kind = low ? tks_pkg::K_LOW : tks_pkg::K_OFFER;
			tks_pkg::OP_DUMP:  kind = tks_pkg::K_DUMP;
			tks_pkg::OP_CLEAR: kind = tks_pkg::K_CLEAR;
			default:           keep = 1'b0;
		endcase
	end

	// Unused op codes are taken and dropped without entering the queue.
	assign in_ready  = !full;
	assign push      = in_valid && !full && keep;
	assign push_data = {kind, cand_score, rect_x, rect_y, rect_w, rect_h};

endmodule

// ----- sv/tks_table.sv -----
module tks_table #(
	parameter int CAPACITY   = 16,
	parameter int COORD_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 empty,
	input  logic [2+tks_pkg::SCORE_W+4*COORD_BITS+2-1:0] pop_data,
	output logic                                 pop,
	input  logic [tks_pkg::MAXE_W-1:0]           max_entries,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tks_pkg::STATUS_W-1:0]         status,
	output logic signed [tks_pkg::SCORE_W-1:0]   out_score,
	output logic [COORD_BITS-1:0]                out_x,
	output logic [COORD_BITS-1:0]                out_y,
	output logic [COORD_BITS:0]                  out_w,
	output logic [COORD_BITS:0]                  out_h,
	output logic [$clog2(CAPACITY+1)-1:0]        entry_count,
	output logic                                 last
);

	localparam int SW    = tks_pkg::SCORE_W;
	localparam int XW    = COORD_BITS;
	localparam int WW    = COORD_BITS + 1;
	localparam int EW    = COORD_BITS + 2;
	localparam int CMD_W = 2 + SW + 2 * XW + 2 * WW;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LVL   = IDX_W;
	localparam int P     = 1 << LVL;
	localparam int LVC_W = $clog2(LVL + 1);
	localparam int LIM_W = (CNT_W > tks_pkg::MAXE_W) ? CNT_W : tks_pkg::MAXE_W;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_CMP     = 6'b000010,
		S_TREE    = 6'b000100,
		S_APPLY   = 6'b001000,
		S_COMPACT = 6'b010000,
		S_DUMP    = 6'b100000
	} state_t;

	state_t state_q, state_n;

	// Entry table
	logic signed [SW-1:0] t_score [CAPACITY];
	logic [XW-1:0]        t_x     [CAPACITY];
	logic [XW-1:0]        t_y     [CAPACITY];
	logic [WW-1:0]        t_w     [CAPACITY];
	logic [WW-1:0]        t_h     [CAPACITY];
	logic [CNT_W-1:0]     count_q, count_n;

	// Command being worked on
	tks_pkg::kind_t       p_kind;
	logic signed [SW-1:0] p_score, c_score_q;
	logic [XW-1:0]        p_x, p_y, c_x_q, c_y_q;
	logic [WW-1:0]        p_w, p_h, c_w_q, c_h_q;

	assign p_h     = pop_data[WW-1:0];
	assign p_w     = pop_data[2*WW-1:WW];
	assign p_y     = pop_data[2*WW+XW-1:2*WW];
	assign p_x     = pop_data[2*WW+2*XW-1:2*WW+XW];
	assign p_score = pop_data[CMD_W-3:CMD_W-2-SW];
	assign p_kind  = tks_pkg::kind_t'(pop_data[CMD_W-1:CMD_W-2]);

	// Lane compare results
	logic [CAPACITY-1:0] live, dom_n, sup_n, dom_q;
	logic                sup_q, none_q, multi_q;
	logic [IDX_W-1:0]    one_idx, one_idx_q;
	logic [EW-1:0]       cand_r, cand_b;

	assign cand_r = {2'b00, c_x_q} + {1'b0, c_w_q};
	assign cand_b = {2'b00, c_y_q} + {1'b0, c_h_q};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_lane
		logic [EW-1:0] tr, tb, rgt, bot;
		logic [XW-1:0] lft, top;
		logic          ovl, lower;
		assign tr    = {2'b00, t_x[i]} + {1'b0, t_w[i]};
		assign tb    = {2'b00, t_y[i]} + {1'b0, t_h[i]};
		assign lft   = (c_x_q > t_x[i]) ? c_x_q : t_x[i];
		assign top   = (c_y_q > t_y[i]) ? c_y_q : t_y[i];
		assign rgt   = (cand_r < tr) ? cand_r : tr;
		assign bot   = (cand_b < tb) ? cand_b : tb;
		assign ovl   = (rgt > {2'b00, lft}) && (bot > {2'b00, top});
		assign lower = (t_score[i] < c_score_q);
		assign live[i]  = (CNT_W'(i) < count_q);
		assign dom_n[i] = live[i] && ovl && lower;
		assign sup_n[i] = live[i] && ovl && !lower;
	end

	always_comb begin
		one_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (dom_n[i]) one_idx = one_idx | IDX_W'(i);
		end
	end

	// Minimum-score tree, one level per cycle
	logic signed [SW-1:0] tr_score [P];
	logic [IDX_W-1:0]     tr_idx   [P];
	logic [P-1:0]         tr_ok;
	logic [LVC_W-1:0]     lvl_q;

	// Room and limit
	logic [LIM_W-1:0] lim;
	logic             room;

	assign lim  = (LIM_W'(max_entries) > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY)
	                                                       : LIM_W'(max_entries);
	assign room = (LIM_W'(count_q) < lim);

	// Read port and scan pointers
	logic [CNT_W-1:0]     rd_q, rd_n, wr_q, wr_n;
	logic [IDX_W-1:0]     rd_idx;
	logic signed [SW-1:0] r_score;
	logic [XW-1:0]        r_x, r_y;
	logic [WW-1:0]        r_w, r_h;

	assign rd_idx  = rd_q[IDX_W-1:0];
	assign r_score = t_score[rd_idx];
	assign r_x     = t_x[rd_idx];
	assign r_y     = t_y[rd_idx];
	assign r_w     = t_w[rd_idx];
	assign r_h     = t_h[rd_idx];

	// Control decisions
	logic              out_free;
	logic              emit, e_dump, e_last;
	tks_pkg::status_t  e_status;
	logic [CNT_W-1:0]  e_count;
	logic              we, w_cand;
	logic [IDX_W-1:0]  w_idx;

	assign out_free = !out_valid || out_ready;

	always_comb begin
		state_n  = state_q;
		count_n  = count_q;
		rd_n     = rd_q;
		wr_n     = wr_q;
		pop      = 1'b0;
		emit     = 1'b0;
		e_dump   = 1'b0;
		e_last   = 1'b1;
		e_status = tks_pkg::ST_LOW;
		e_count  = count_q;
		we       = 1'b0;
		w_cand   = 1'b1;
		w_idx    = count_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (!empty) begin
					unique case (p_kind)
						tks_pkg::K_OFFER: begin
							pop     = 1'b1;
							state_n = S_CMP;
						end
						tks_pkg::K_LOW: begin
							if (out_free) begin
								pop  = 1'b1;
								emit = 1'b1;
							end
						end
						tks_pkg::K_CLEAR: begin
							if (out_free) begin
								pop      = 1'b1;
								emit     = 1'b1;
								e_status = tks_pkg::ST_CLEARED;
								e_count  = '0;
								count_n  = '0;
							end
						end
						tks_pkg::K_DUMP: begin
							pop  = 1'b1;
							rd_n = '0;
							if (count_q != '0) state_n = S_DUMP;
						end
						default: ;
					endcase
				end
			end
			S_CMP: begin
				if ((dom_n == '0) && (sup_n == '0) && !room) state_n = S_TREE;
				else state_n = S_APPLY;
			end
			S_TREE: begin
				if (lvl_q == LVC_W'(LVL - 1)) state_n = S_APPLY;
			end
			S_APPLY: begin
				if (out_free) begin
					emit    = 1'b1;
					state_n = S_IDLE;
					if (sup_q) begin
						e_status = tks_pkg::ST_SUPPRESSED;
					end else if (none_q) begin
						if (room) begin
							we       = 1'b1;
							count_n  = count_q + 1'b1;
							e_count  = count_q + 1'b1;
							e_status = tks_pkg::ST_APPENDED;
						end else if (tr_ok[0] && (tr_score[0] < c_score_q)) begin
							we       = 1'b1;
							w_idx    = tr_idx[0];
							e_status = tks_pkg::ST_REPL_WORST;
						end else begin
							e_status = tks_pkg::ST_FULL;
						end
					end else if (!multi_q) begin
						we       = 1'b1;
						w_idx    = one_idx_q;
						e_status = tks_pkg::ST_REPL_ONE;
					end else begin
						emit    = 1'b0;
						rd_n    = '0;
						wr_n    = '0;
						state_n = S_COMPACT;
					end
				end
			end
			S_COMPACT: begin
				w_idx = wr_q[IDX_W-1:0];
				if (rd_q != count_q) begin
					rd_n = rd_q + 1'b1;
					if (!dom_q[rd_idx]) begin
						we     = 1'b1;
						w_cand = 1'b0;
						wr_n   = wr_q + 1'b1;
					end
				end else if (out_free) begin
					we       = 1'b1;
					count_n  = wr_q + 1'b1;
					e_count  = wr_q + 1'b1;
					emit     = 1'b1;
					e_status = tks_pkg::ST_MERGED;
					state_n  = S_IDLE;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					emit     = 1'b1;
					e_dump   = 1'b1;
					e_status = tks_pkg::ST_ENTRY;
					e_last   = ((rd_q + 1'b1) == count_q);
					rd_n     = rd_q + 1'b1;
					if (e_last) state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			lvl_q   <= '0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			rd_q    <= rd_n;
			wr_q    <= wr_n;
			if (state_q == S_TREE) lvl_q <= lvl_q + 1'b1;
			else lvl_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			c_score_q <= p_score;
			c_x_q     <= p_x;
			c_y_q     <= p_y;
			c_w_q     <= p_w;
			c_h_q     <= p_h;
		end
		if (state_q == S_CMP) begin
			dom_q     <= dom_n;
			sup_q     <= |sup_n;
			none_q    <= (dom_n == '0);
			multi_q   <= |(dom_n & (dom_n - 1'b1));
			one_idx_q <= one_idx;
			for (int k = 0; k < CAPACITY; k++) begin
				tr_score[k] <= t_score[k];
				tr_idx[k]   <= IDX_W'(k);
				tr_ok[k]    <= live[k];
			end
			for (int k = CAPACITY; k < P; k++) begin
				tr_ok[k] <= 1'b0;
			end
		end else if (state_q == S_TREE) begin
			// Left wins a tie, so the earliest lowest entry survives.
			for (int k = 0; k < P / 2; k++) begin
				if (tr_ok[2*k] && (!tr_ok[2*k+1] || (tr_score[2*k] <= tr_score[2*k+1]))) begin
					tr_score[k] <= tr_score[2*k];
					tr_idx[k]   <= tr_idx[2*k];
					tr_ok[k]    <= 1'b1;
				end else begin
					tr_score[k] <= tr_score[2*k+1];
					tr_idx[k]   <= tr_idx[2*k+1];
					tr_ok[k]    <= tr_ok[2*k+1];
				end
			end
		end
		if (we) begin
			t_score[w_idx] <= w_cand ? c_score_q : r_score;
			t_x[w_idx]     <= w_cand ? c_x_q : r_x;
			t_y[w_idx]     <= w_cand ? c_y_q : r_y;
			t_w[w_idx]     <= w_cand ? c_w_q : r_w;
			t_h[w_idx]     <= w_cand ? c_h_q : r_h;
		end
	end

	// Output register
	logic                 out_valid_q;
	tks_pkg::status_t     status_q;
	logic signed [SW-1:0] o_score_q;
	logic [XW-1:0]        o_x_q, o_y_q;
	logic [WW-1:0]        o_w_q, o_h_q;
	logic [CNT_W-1:0]     o_count_q;
	logic                 o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= e_status;
			o_score_q <= e_dump ? r_score : '0;
			o_x_q     <= e_dump ? r_x : '0;
			o_y_q     <= e_dump ? r_y : '0;
			o_w_q     <= e_dump ? r_w : '0;
			o_h_q     <= e_dump ? r_h : '0;
			o_count_q <= e_count;
			o_last_q  <= e_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_score   = o_score_q;
	assign out_x       = o_x_q;
	assign out_y       = o_y_q;
	assign out_w       = o_w_q;
	assign out_h       = o_h_q;
	assign entry_count = o_count_q;
	assign last        = o_last_q;

endmodule

// ----- sv/topk_roi_overlap_suppressor.sv -----
// Greedy overlap suppression over a small table of scored rectangles.
// Input channel (in_valid/in_ready): one transaction carries an operation: offer a
// candidate, dump the table or clear it. Output channel (out_valid/out_ready): one
// transaction per offer or clear, one per held entry on a dump, with last marking the
// final transaction caused by an input. A dump of an empty table and the unused
// operation code produce nothing.
// With an empty queue and a free output register, a clear or a low-score drop goes
// straight from the queue into the output register, while an offer that finds room or
// overlaps first passes through the compare and apply steps. An offer to a full table
// with no overlap adds the lowest-score tree search, and a merge of several overlapped
// entries adds a compaction pass through the single table read port. A dump offers its
// entries in table order through the same read port. The engine finishes one command
// before it takes the next one from the queue.
// A two-deep command queue sits between the front end and the table engine, so new
// input transactions are taken while a result waits in the output register.
// When the receiver stalls, the engine waits at its next result and the queue fills,
// after which in_ready drops. Reset empties the table and the queue and restores the
// default threshold and size limit. Configuration writes take effect at once; the user
// must make them while the block is idle, which the block itself does not enforce.
module topk_roi_overlap_suppressor #(
	parameter int CAPACITY   = 16,
	parameter int COORD_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [tks_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         op,
	input  logic signed [tks_pkg::SCORE_W-1:0] cand_score,
	input  logic [COORD_BITS-1:0]              rect_x,
	input  logic [COORD_BITS-1:0]              rect_y,
	input  logic [COORD_BITS:0]                rect_w,
	input  logic [COORD_BITS:0]                rect_h,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tks_pkg::STATUS_W-1:0]       status,
	output logic signed [tks_pkg::SCORE_W-1:0] out_score,
	output logic [COORD_BITS-1:0]              out_x,
	output logic [COORD_BITS-1:0]              out_y,
	output logic [COORD_BITS:0]                out_w,
	output logic [COORD_BITS:0]                out_h,
	output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
	output logic                               last
);

	localparam int CMD_W = 2 + tks_pkg::SCORE_W + 4 * COORD_BITS + 2;

	// Configuration registers.
	logic [tks_pkg::MIN_W-1:0]  min_score_q;
	logic [tks_pkg::MAXE_W-1:0] max_entries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_score_q   <= tks_pkg::MIN_SCORE_RST;
			max_entries_q <= tks_pkg::MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tks_pkg::CFG_MIN_SCORE:   min_score_q   <= cfg_data[tks_pkg::MIN_W-1:0];
				tks_pkg::CFG_MAX_ENTRIES: max_entries_q <= cfg_data[tks_pkg::MAXE_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end classifies each transaction; the queue decouples it from the engine.
	logic             push, pop, full, empty;
	logic [CMD_W-1:0] push_data, pop_data;

	tks_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.cand_score (cand_score),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.min_score  (min_score_q),
		.full       (full),
		.push       (push),
		.push_data  (push_data)
	);

	tks_fifo #(
		.W (CMD_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// The engine holds the table, runs the compare lanes, the lowest-score tree and
	// the compaction and dump scans, and owns the output register.
	tks_table #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.pop_data    (pop_data),
		.pop         (pop),
		.max_entries (max_entries_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_score   (out_score),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_w       (out_w),
		.out_h       (out_h),
		.entry_count (entry_count),
		.last        (last)
	);

endmodule

// ----- sv/tks_checker.sv -----
module tks_checker #(
	parameter int CAPACITY   = 16,
	parameter int COORD_BITS = 10
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [tks_pkg::STATUS_W-1:0]       status,
	input logic signed [tks_pkg::SCORE_W-1:0] out_score,
	input logic [COORD_BITS-1:0]              out_x,
	input logic [COORD_BITS-1:0]              out_y,
	input logic [COORD_BITS:0]                out_w,
	input logic [COORD_BITS:0]                out_h,
	input logic [$clog2(CAPACITY+1)-1:0]      entry_count,
	input logic                               last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count)
			&& $stable(last))
		else $error("result changed while stalled");

	a_nondump_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != tks_pkg::ST_ENTRY) |-> last && (out_score == '0)
			&& (out_x == '0) && (out_y == '0) && (out_w == '0) && (out_h == '0))
		else $error("non-dump result carries entry fields or is not last");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tks_pkg::ST_CLEARED) |-> (entry_count == '0))
		else $error("clear result reports a nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == tks_pkg::ST_APPENDED) || (status == tks_pkg::ST_MERGED)
			|| (status == tks_pkg::ST_ENTRY))
		|-> (entry_count != '0) && (entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count out of range");

endmodule

bind topk_roi_overlap_suppressor tks_checker #(
	.CAPACITY   (CAPACITY),
	.COORD_BITS (COORD_BITS)
) u_tks_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.out_score   (out_score),
	.out_x       (out_x),
	.out_y       (out_y),
	.out_w       (out_w),
	.out_h       (out_h),
	.entry_count (entry_count),
	.last        (last)
);
